/* hw/rtl/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// Holds the request, response, table entry and compare-unit types.
// No dependencies.
package ffba_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 24;
   localparam int CSR_IDX_W        = 4;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NOSPACE = 3'd2,
      ST_IGNORED = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAP_START = 4'd0,
      CSR_HEAP_LIMIT = 4'd1
   } csr_index_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] req_size;
      logic [31:0] user_addr;
   } req_data_type;

   typedef struct packed {
      logic [31:0] result_addr;
      status_type  status;
   } rsp_data_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] bytes;
      logic        free;
   } tbl_entry_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic        add_hdr;
   } alu_req_type;

   typedef struct packed {
      logic [33:0] sum;
      logic        eq;
      logic        gt;
   } alu_rsp_type;

endpackage

/* hw/rtl/ffba_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ffba_alu.sv */
// Shared add-and-compare unit of the allocator: a + b (+ header), checked
// against c. Depends on ffba_pkg.
module ffba_alu import ffba_pkg::*; #(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [33:0] hdr;
   logic [33:0] sum;
   logic [33:0] ref_val;

   always_comb begin
      hdr     = alu_req.add_hdr ? 34'(HEADER_BYTES) : 34'd0;
      sum     = {2'b00, alu_req.a} + {2'b00, alu_req.b} + hdr;
      ref_val = {2'b00, alu_req.c};
      alu_rsp.sum = sum;
      alu_rsp.eq  = (sum == ref_val);
      alu_rsp.gt  = (sum > ref_val);
   end

endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// First-fit block allocator: a sequencer that walks the block table in RAM and
// drives one shared add-and-compare unit. Depends on ffba_pkg, ffba_ram, ffba_alu.
//
// Each request transfer is an allocate or a free and yields exactly one
// response transfer. The block table lives in a single RAM with a registered
// read, and the sequencer streams one table entry per cycle through the shared
// compare unit. A free is answered from the scan itself; an allocate that
// reuses a free block goes on to S_FINISH to form the address, and one that
// appends a block goes through S_APPEND and then S_FINISH. A zero-size
// allocate or a null free is answered straight from idle, with no scan. The
// scan reads at most block_count entries, so it grows with the table. The
// request side is ready only while the sequencer is idle and the response
// register is free or being emptied. Configuration writes are taken only
// while the sequencer is idle. The table needs no clearing pass after reset:
// only entries below the block count are ever read.
module first_fit_block_allocator import ffba_pkg::*; #(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_data_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ENTRY_W = $bits(tbl_entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPEND,
      S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [31:0]   size_ff, size_in;
   logic [31:0]   addr_ff, addr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]   break_ff, break_in;
   logic [31:0]   heap_start_ff, heap_start_in;
   logic [31:0]   heap_limit_ff, heap_limit_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [31:0]   hit_start_ff, hit_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_wr_addr;
   tbl_entry_type    ram_wr_entry;
   logic             ram_re;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_bits;
   tbl_entry_type    rd_entry;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic        req_fire;
   logic        hit;
   logic [31:0] brk;

   assign rd_entry = tbl_entry_type'(ram_rd_bits);

   ffba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   ffba_alu #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // The request side waits for the response register to drain, so a finished
   // result always finds the register free.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   // Register writes wait until no request is being worked on.
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The break comes from heap_start while the table is still empty.
   assign brk = (count_ff == '0) ? heap_start_ff : break_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      break_in      = break_ff;
      heap_start_in = heap_start_ff;
      heap_limit_in = heap_limit_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_start_in  = hit_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      ram_we       = 1'b0;
      ram_wr_addr  = cmp_idx_ff;
      ram_wr_entry = rd_entry;
      ram_re       = 1'b0;
      ram_rd_addr  = issue_ff[IDX_W-1:0];

      // In the scan the unit checks the entry read in the previous cycle.
      alu_req.a       = rd_entry.bytes;
      alu_req.b       = 32'd0;
      alu_req.c       = size_ff;
      alu_req.add_hdr = 1'b0;
      if (op_ff == OP_FREE) begin
         alu_req.a       = rd_entry.start;
         alu_req.c       = addr_ff;
         alu_req.add_hdr = 1'b1;
      end
      hit = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAP_START: heap_start_in = csr_wdata;
            CSR_HEAP_LIMIT: heap_limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_data.op;
               size_in  = req_data.req_size;
               addr_in  = req_data.user_addr;
               issue_in = '0;
               if (req_data.op == OP_ALLOC && req_data.req_size == 32'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{result_addr: 32'd0, status: ST_ZERO};
               end else if (req_data.op == OP_FREE && req_data.user_addr == 32'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{result_addr: 32'd0, status: ST_IGNORED};
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (op_ff == OP_ALLOC) begin
               hit = pend_ff && rd_entry.free && (alu_rsp.gt || alu_rsp.eq);
            end else begin
               hit = pend_ff && alu_rsp.eq;
            end

            if (hit) begin
               if (op_ff == OP_ALLOC) begin
                  // Reuse the block as it is; the address is formed next cycle.
                  ram_we            = 1'b1;
                  ram_wr_entry.free = 1'b0;
                  hit_start_in      = rd_entry.start;
                  state_in          = S_FINISH;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (rd_entry.free) begin
                     rsp_data_in = '{result_addr: 32'd0, status: ST_IGNORED};
                  end else begin
                     ram_we            = 1'b1;
                     ram_wr_entry.free = 1'b1;
                     rsp_data_in       = '{result_addr: 32'd0, status: ST_DONE};
                  end
               end
            end else if (issue_ff < count_ff) begin
               ram_re     = 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else if (op_ff == OP_ALLOC) begin
               state_in = S_APPEND;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{result_addr: 32'd0, status: ST_UNKNOWN};
               state_in     = S_IDLE;
            end
         end

         S_APPEND: begin
            alu_req.a       = brk;
            alu_req.b       = size_ff;
            alu_req.c       = heap_limit_ff;
            alu_req.add_hdr = 1'b1;
            if (count_ff == CNT_W'(MAX_BLOCKS) || alu_rsp.gt) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{result_addr: 32'd0, status: ST_NOSPACE};
               state_in     = S_IDLE;
            end else begin
               ram_we       = 1'b1;
               ram_wr_addr  = count_ff[IDX_W-1:0];
               ram_wr_entry = '{start: brk, bytes: size_ff, free: 1'b0};
               count_in     = count_ff + CNT_W'(1);
               break_in     = alu_rsp.sum[31:0];
               hit_start_in = brk;
               state_in     = S_FINISH;
            end
         end

         S_FINISH: begin
            alu_req.a       = hit_start_ff;
            alu_req.b       = 32'd0;
            alu_req.c       = 32'd0;
            alu_req.add_hdr = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_data_in     = '{result_addr: alu_rsp.sum[31:0], status: ST_DONE};
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_start_ff <= hit_start_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         break_ff      <= 32'd0;
         heap_start_ff <= 32'd0;
         heap_limit_ff <= 32'd65536;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         break_ff      <= break_in;
         heap_start_ff <= heap_start_in;
         heap_limit_ff <= heap_limit_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The block count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count beyond table depth");

   // Only an append changes the block count.
   a_count_only_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_APPEND) |=> $stable(count_ff))
      else $error("block count changed outside an append");

   // A write that is not an append only touches an entry already in the table.
   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_APPEND) |-> (CNT_W'(cmp_idx_ff) < count_ff))
      else $error("table write outside the used entries");

   // An accepted request either answers at once or starts the scan.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || state_ff == S_SCAN))
      else $error("accepted request made no progress");

endmodule
